### hw/rtl/bss_pkg.sv
// Shared constants and types for the box subtraction splitter.
`timescale 1ns / 1ps
package bss_pkg;

	localparam int PIECE_MAX   = 6;
	localparam int REC_COORDS  = 18;
	localparam int QUEUE_DEPTH = 2;

	localparam int AX_X = 0;
	localparam int AX_Y = 1;
	localparam int AX_Z = 2;

	typedef enum logic [2:0] {
		SIDE_ABOVE  = 3'd0,
		SIDE_BELOW  = 3'd1,
		SIDE_HIGH_Y = 3'd2,
		SIDE_LOW_Y  = 3'd3,
		SIDE_HIGH_X = 3'd4,
		SIDE_LOW_X  = 3'd5
	} side_t;

endpackage

### hw/rtl/bss_front.sv
// Front end: accepts items, clamps the cutter and classifies the sides.
`timescale 1ns / 1ps
module bss_front
	import bss_pkg::*;
#(
	parameter int COORD_BITS = 16,
	localparam int REC_W = REC_COORDS * COORD_BITS + PIECE_MAX
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic signed [COORD_BITS-1:0] src_high_x,
	input  logic signed [COORD_BITS-1:0] src_high_y,
	input  logic signed [COORD_BITS-1:0] src_high_z,
	input  logic signed [COORD_BITS-1:0] src_low_x,
	input  logic signed [COORD_BITS-1:0] src_low_y,
	input  logic signed [COORD_BITS-1:0] src_low_z,
	input  logic signed [COORD_BITS-1:0] cut_high_x,
	input  logic signed [COORD_BITS-1:0] cut_high_y,
	input  logic signed [COORD_BITS-1:0] cut_high_z,
	input  logic signed [COORD_BITS-1:0] cut_low_x,
	input  logic signed [COORD_BITS-1:0] cut_low_y,
	input  logic signed [COORD_BITS-1:0] cut_low_z,
	output logic                         q_wr,
	input  logic                         q_full,
	output logic [REC_W-1:0]             q_data
);

	typedef struct packed {
		logic [PIECE_MAX-1:0]         mask;
		logic [2:0][COORD_BITS-1:0]   sh;
		logic [2:0][COORD_BITS-1:0]   sl;
		logic [2:0][COORD_BITS-1:0]   ch;
		logic [2:0][COORD_BITS-1:0]   cl;
		logic [2:0][COORD_BITS-1:0]   chp;
		logic [2:0][COORD_BITS-1:0]   clm;
	} rec_t;

	logic [2:0][COORD_BITS-1:0] src_hi, src_lo, cut_hi, cut_lo;
	logic [2:0][COORD_BITS-1:0] clamp_hi, clamp_lo;
	logic [2:0][COORD_BITS-1:0] sh_s1, sl_s1, ch_s1, cl_s1;
	logic                       valid_s1;
	logic                       adv;
	rec_t                       rec;

	assign src_hi = {src_high_z, src_high_y, src_high_x};
	assign src_lo = {src_low_z, src_low_y, src_low_x};
	assign cut_hi = {cut_high_z, cut_high_y, cut_high_x};
	assign cut_lo = {cut_low_z, cut_low_y, cut_low_x};

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			clamp_hi[a] = ($signed(cut_hi[a]) > $signed(src_hi[a])) ? src_hi[a] : cut_hi[a];
			clamp_lo[a] = ($signed(cut_lo[a]) < $signed(src_lo[a])) ? src_lo[a] : cut_lo[a];
		end
	end

	assign adv  = !valid_s1 || !q_full;
	assign full = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && push) begin
			sh_s1 <= src_hi;
			sl_s1 <= src_lo;
			ch_s1 <= clamp_hi;
			cl_s1 <= clamp_lo;
		end
	end

	always_comb begin
		rec.sh = sh_s1;
		rec.sl = sl_s1;
		rec.ch = ch_s1;
		rec.cl = cl_s1;
		for (int a = 0; a < 3; a++) begin
			rec.chp[a] = ch_s1[a] + COORD_BITS'(1);
			rec.clm[a] = cl_s1[a] - COORD_BITS'(1);
		end
		rec.mask              = '0;
		rec.mask[SIDE_ABOVE]  = $signed(sh_s1[AX_Z]) > $signed(ch_s1[AX_Z]);
		rec.mask[SIDE_BELOW]  = $signed(sl_s1[AX_Z]) < $signed(cl_s1[AX_Z]);
		rec.mask[SIDE_HIGH_Y] = $signed(sh_s1[AX_Y]) > $signed(ch_s1[AX_Y]);
		rec.mask[SIDE_LOW_Y]  = $signed(sl_s1[AX_Y]) < $signed(cl_s1[AX_Y]);
		rec.mask[SIDE_HIGH_X] = $signed(sh_s1[AX_X]) > $signed(ch_s1[AX_X]);
		rec.mask[SIDE_LOW_X]  = $signed(sl_s1[AX_X]) < $signed(cl_s1[AX_X]);
	end

	assign q_wr   = valid_s1 && !q_full;
	assign q_data = rec;

endmodule

### hw/rtl/bss_queue.sv
// Short queue of classified items between the front and back ends.
`timescale 1ns / 1ps
module bss_queue
	import bss_pkg::*;
#(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	output logic         full,
	input  logic         rd_en,
	output logic         rd_valid,
	output logic [W-1:0] rd_data
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [W-1:0]     mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign full     = count_q == CNT_W'(QUEUE_DEPTH);
	assign rd_valid = count_q != '0;
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

### hw/rtl/bss_back.sv
// Back end: walks the side mask, one child box per unstalled cycle.
`timescale 1ns / 1ps
module bss_back
	import bss_pkg::*;
#(
	parameter int COORD_BITS = 16,
	localparam int REC_W = REC_COORDS * COORD_BITS + PIECE_MAX
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  logic [REC_W-1:0]             q_data,
	output logic                         q_rd,
	output logic                         empty,
	input  logic                         pop,
	output logic signed [COORD_BITS-1:0] piece_high_x,
	output logic signed [COORD_BITS-1:0] piece_high_y,
	output logic signed [COORD_BITS-1:0] piece_high_z,
	output logic signed [COORD_BITS-1:0] piece_low_x,
	output logic signed [COORD_BITS-1:0] piece_low_y,
	output logic signed [COORD_BITS-1:0] piece_low_z,
	output logic [2:0]                   piece_side,
	output logic                         piece_last,
	output logic                         no_pieces
);

	typedef struct packed {
		logic [PIECE_MAX-1:0]         mask;
		logic [2:0][COORD_BITS-1:0]   sh;
		logic [2:0][COORD_BITS-1:0]   sl;
		logic [2:0][COORD_BITS-1:0]   ch;
		logic [2:0][COORD_BITS-1:0]   cl;
		logic [2:0][COORD_BITS-1:0]   chp;
		logic [2:0][COORD_BITS-1:0]   clm;
	} rec_t;

	rec_t                       cur_q;
	logic                       cur_v_q;
	logic [PIECE_MAX-1:0]       rem_q, rem_next;
	side_t                      side_idx;
	logic                       none, last_now;
	logic                       out_load, emit, done;
	logic [2:0][COORD_BITS-1:0] hi, lo;

	logic                       out_v_q;
	logic [2:0][COORD_BITS-1:0] hi_q, lo_q;
	side_t                      side_q;
	logic                       last_q, none_q;

	always_comb begin
		side_idx = SIDE_ABOVE;
		for (int i = PIECE_MAX - 1; i >= 0; i--) begin
			if (rem_q[i]) begin
				side_idx = side_t'(3'(i));
			end
		end
	end

	assign rem_next = rem_q & (rem_q - PIECE_MAX'(1));
	assign none     = rem_q == '0;
	assign last_now = rem_next == '0;

	always_comb begin
		hi = cur_q.sh;
		lo = cur_q.sl;
		unique case (side_idx)
			SIDE_ABOVE: begin
				lo[AX_Z] = cur_q.chp[AX_Z];
			end
			SIDE_BELOW: begin
				hi[AX_Z] = cur_q.clm[AX_Z];
			end
			SIDE_HIGH_Y: begin
				hi[AX_Z] = cur_q.ch[AX_Z];
				lo[AX_Y] = cur_q.chp[AX_Y];
				lo[AX_Z] = cur_q.cl[AX_Z];
			end
			SIDE_LOW_Y: begin
				hi[AX_Y] = cur_q.clm[AX_Y];
				hi[AX_Z] = cur_q.ch[AX_Z];
				lo[AX_Z] = cur_q.cl[AX_Z];
			end
			SIDE_HIGH_X: begin
				hi[AX_Y] = cur_q.ch[AX_Y];
				hi[AX_Z] = cur_q.ch[AX_Z];
				lo[AX_X] = cur_q.chp[AX_X];
				lo[AX_Y] = cur_q.cl[AX_Y];
				lo[AX_Z] = cur_q.cl[AX_Z];
			end
			SIDE_LOW_X: begin
				hi[AX_X] = cur_q.clm[AX_X];
				hi[AX_Y] = cur_q.ch[AX_Y];
				hi[AX_Z] = cur_q.ch[AX_Z];
				lo[AX_Y] = cur_q.cl[AX_Y];
				lo[AX_Z] = cur_q.cl[AX_Z];
			end
			default: begin
				hi = cur_q.sh;
				lo = cur_q.sl;
			end
		endcase
		if (none) begin
			hi = '0;
			lo = '0;
		end
	end

	assign out_load = !out_v_q || pop;
	assign emit     = cur_v_q && out_load;
	assign done     = emit && last_now;
	assign q_rd     = q_valid && (!cur_v_q || done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			rem_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (q_rd) begin
				cur_v_q <= 1'b1;
				rem_q   <= q_data[REC_W-1 -: PIECE_MAX];
			end else if (emit) begin
				cur_v_q <= !done;
				rem_q   <= rem_next;
			end
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			cur_q <= q_data;
		end
		if (emit) begin
			hi_q   <= hi;
			lo_q   <= lo;
			side_q <= none ? SIDE_ABOVE : side_idx;
			last_q <= last_now;
			none_q <= none;
		end
	end

	assign empty        = !out_v_q;
	assign piece_high_x = hi_q[AX_X];
	assign piece_high_y = hi_q[AX_Y];
	assign piece_high_z = hi_q[AX_Z];
	assign piece_low_x  = lo_q[AX_X];
	assign piece_low_y  = lo_q[AX_Y];
	assign piece_low_z  = lo_q[AX_Z];
	assign piece_side   = side_q;
	assign piece_last   = last_q;
	assign no_pieces    = none_q;

endmodule

### hw/rtl/box_subtract_split_top.sv
// Top level of the axis-aligned 3D box subtraction splitter.
`timescale 1ns / 1ps
// Usage:
//   Input queue port: drive the twelve source and cutter corner fields with push
//   high; the item is taken at a rising edge where push is high and full is low.
//   Result queue port: while empty is low the oldest child box is on the piece
//   ports; it is taken at a rising edge where pop is high. An item yields one to
//   six results in the order above, below, higher y, lower y, higher x, lower x;
//   piece_last marks its final one. When the cutter covers the source a single
//   result with no_pieces set and zero coordinates is given.
// Data path and flow:
//   The first result of an item passes the clamp register, the queue, the back
//   end's current item register and the output register. While pop is high the
//   back end issues one result per cycle, and the input takes items back to back
//   while pieces are issued.
//   A clamp stage, a two-entry queue and the output register decouple the sides.
// Reset and stalls:
//   arst_n clears all queues and valid flags; nothing is shown until new items
//   arrive. When pop stays low the shown result holds, the back end stops and the
//   queue and clamp stage fill, after which full rises.
module box_subtract_split_top
	import bss_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic signed [COORD_BITS-1:0] src_high_x,
	input  logic signed [COORD_BITS-1:0] src_high_y,
	input  logic signed [COORD_BITS-1:0] src_high_z,
	input  logic signed [COORD_BITS-1:0] src_low_x,
	input  logic signed [COORD_BITS-1:0] src_low_y,
	input  logic signed [COORD_BITS-1:0] src_low_z,
	input  logic signed [COORD_BITS-1:0] cut_high_x,
	input  logic signed [COORD_BITS-1:0] cut_high_y,
	input  logic signed [COORD_BITS-1:0] cut_high_z,
	input  logic signed [COORD_BITS-1:0] cut_low_x,
	input  logic signed [COORD_BITS-1:0] cut_low_y,
	input  logic signed [COORD_BITS-1:0] cut_low_z,
	output logic                         empty,
	input  logic                         pop,
	output logic signed [COORD_BITS-1:0] piece_high_x,
	output logic signed [COORD_BITS-1:0] piece_high_y,
	output logic signed [COORD_BITS-1:0] piece_high_z,
	output logic signed [COORD_BITS-1:0] piece_low_x,
	output logic signed [COORD_BITS-1:0] piece_low_y,
	output logic signed [COORD_BITS-1:0] piece_low_z,
	output logic [2:0]                   piece_side,
	output logic                         piece_last,
	output logic                         no_pieces
);

	localparam int REC_W = REC_COORDS * COORD_BITS + PIECE_MAX;

	logic             q_wr, q_full, q_rd, q_valid;
	logic [REC_W-1:0] q_wdata, q_rdata;

	bss_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.src_high_x(src_high_x),
		.src_high_y(src_high_y),
		.src_high_z(src_high_z),
		.src_low_x (src_low_x),
		.src_low_y (src_low_y),
		.src_low_z (src_low_z),
		.cut_high_x(cut_high_x),
		.cut_high_y(cut_high_y),
		.cut_high_z(cut_high_z),
		.cut_low_x (cut_low_x),
		.cut_low_y (cut_low_y),
		.cut_low_z (cut_low_z),
		.q_wr      (q_wr),
		.q_full    (q_full),
		.q_data    (q_wdata)
	);

	bss_queue #(
		.W(REC_W)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_data (q_wdata),
		.full    (q_full),
		.rd_en   (q_rd),
		.rd_valid(q_valid),
		.rd_data (q_rdata)
	);

	bss_back #(
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_data      (q_rdata),
		.q_rd        (q_rd),
		.empty       (empty),
		.pop         (pop),
		.piece_high_x(piece_high_x),
		.piece_high_y(piece_high_y),
		.piece_high_z(piece_high_z),
		.piece_low_x (piece_low_x),
		.piece_low_y (piece_low_y),
		.piece_low_z (piece_low_z),
		.piece_side  (piece_side),
		.piece_last  (piece_last),
		.no_pieces   (no_pieces)
	);

endmodule

### hw/rtl/bss_checker.sv
// Port-level checks on the result queue of the box subtraction splitter.
`timescale 1ns / 1ps
module bss_checker
	import bss_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         empty,
	input logic                         pop,
	input logic signed [COORD_BITS-1:0] piece_high_x,
	input logic signed [COORD_BITS-1:0] piece_high_y,
	input logic signed [COORD_BITS-1:0] piece_high_z,
	input logic signed [COORD_BITS-1:0] piece_low_x,
	input logic signed [COORD_BITS-1:0] piece_low_y,
	input logic signed [COORD_BITS-1:0] piece_low_z,
	input logic [2:0]                   piece_side,
	input logic                         piece_last,
	input logic                         no_pieces
);

	// an empty-cut result is alone and carries zeroes
	a_none_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && no_pieces) |-> (piece_last && piece_side == SIDE_ABOVE))
		else $error("no_pieces result without piece_last or with a side");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && no_pieces) |-> (piece_high_x == '0 && piece_high_y == '0 &&
			piece_high_z == '0 && piece_low_x == '0 && piece_low_y == '0 &&
			piece_low_z == '0))
		else $error("no_pieces result with non-zero corners");

	a_side_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (piece_side != 3'd6 && piece_side != 3'd7))
		else $error("piece_side out of range");

	// pieces of one item come in rising side order
	a_side_order: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !piece_last) ##1 !empty |->
			(piece_side > $past(piece_side) && !no_pieces))
		else $error("pieces of one item out of order");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(piece_high_x) && $stable(piece_low_x) &&
			$stable(piece_side) && $stable(piece_last) && $stable(no_pieces)))
		else $error("stalled result changed");

endmodule

bind box_subtract_split_top bss_checker #(.COORD_BITS(COORD_BITS)) u_bss_checker (.*);

### verif/box_subtract_split_top_tb.sv
// Self-checking testbench for the box subtraction splitter: random and directed boxes.
`timescale 1ns / 1ps
module box_subtract_split_top_tb;
	import bss_pkg::*;

	localparam int COORD_BITS = 16;
	localparam int WATCHDOG   = 3000;
	localparam int HOLD_LEN   = 150;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t shx, shy, shz, slx, sly, slz;
		coord_t chx, chy, chz, clx, cly, clz;
	} boxes_t;

	typedef struct packed {
		coord_t hx, hy, hz, lx, ly, lz;
		side_t  side;
		logic   last;
		logic   covered;
	} piece_t;

	class piece_checker;
		piece_t pending[$];
		int     mismatches;

		function piece_t make_piece(input coord_t hx, hy, hz, lx, ly, lz, input side_t side);
			piece_t p;
			p.hx = hx; p.hy = hy; p.hz = hz;
			p.lx = lx; p.ly = ly; p.lz = lz;
			p.side = side;
			p.last = 1'b0;
			p.covered = 1'b0;
			return p;
		endfunction

		// clamp cutter into source, then carve the six slabs in fixed order
		function void note_boxes(boxes_t b);
			coord_t sh[3], sl[3], ch[3], cl[3];
			piece_t cut[$];
			piece_t p;
			sh[AX_X] = b.shx; sh[AX_Y] = b.shy; sh[AX_Z] = b.shz;
			sl[AX_X] = b.slx; sl[AX_Y] = b.sly; sl[AX_Z] = b.slz;
			ch[AX_X] = b.chx; ch[AX_Y] = b.chy; ch[AX_Z] = b.chz;
			cl[AX_X] = b.clx; cl[AX_Y] = b.cly; cl[AX_Z] = b.clz;
			for (int a = 0; a < 3; a++) begin
				if (ch[a] > sh[a]) ch[a] = sh[a];
				if (cl[a] < sl[a]) cl[a] = sl[a];
			end
			if (sh[AX_Z] > ch[AX_Z])
				cut.push_back(make_piece(sh[AX_X], sh[AX_Y], sh[AX_Z],
					sl[AX_X], sl[AX_Y], coord_t'(ch[AX_Z] + 1), SIDE_ABOVE));
			if (sl[AX_Z] < cl[AX_Z])
				cut.push_back(make_piece(sh[AX_X], sh[AX_Y], coord_t'(cl[AX_Z] - 1),
					sl[AX_X], sl[AX_Y], sl[AX_Z], SIDE_BELOW));
			if (sh[AX_Y] > ch[AX_Y])
				cut.push_back(make_piece(sh[AX_X], sh[AX_Y], ch[AX_Z],
					sl[AX_X], coord_t'(ch[AX_Y] + 1), cl[AX_Z], SIDE_HIGH_Y));
			if (sl[AX_Y] < cl[AX_Y])
				cut.push_back(make_piece(sh[AX_X], coord_t'(cl[AX_Y] - 1), ch[AX_Z],
					sl[AX_X], sl[AX_Y], cl[AX_Z], SIDE_LOW_Y));
			if (sh[AX_X] > ch[AX_X])
				cut.push_back(make_piece(sh[AX_X], ch[AX_Y], ch[AX_Z],
					coord_t'(ch[AX_X] + 1), cl[AX_Y], cl[AX_Z], SIDE_HIGH_X));
			if (sl[AX_X] < cl[AX_X])
				cut.push_back(make_piece(coord_t'(cl[AX_X] - 1), ch[AX_Y], ch[AX_Z],
					sl[AX_X], cl[AX_Y], cl[AX_Z], SIDE_LOW_X));
			if (cut.size() == 0) begin
				p = '0;
				p.side = SIDE_ABOVE;
				p.last = 1'b1;
				p.covered = 1'b1;
				cut.push_back(p);
			end else begin
				cut[cut.size() - 1].last = 1'b1;
			end
			foreach (cut[i])
				pending.push_back(cut[i]);
		endfunction

		function string fmt(piece_t p);
			return $sformatf("hi %0d %0d %0d lo %0d %0d %0d side %0d last %0b covered %0b",
				$signed(p.hx), $signed(p.hy), $signed(p.hz),
				$signed(p.lx), $signed(p.ly), $signed(p.lz),
				p.side, p.last, p.covered);
		endfunction

		function void check_piece(piece_t got);
			piece_t want;
			bit bad;
			if (pending.size() == 0) begin
				if (mismatches < 10)
					$display("ERROR %0t: unexpected piece %s", $realtime, fmt(got));
				mismatches++;
				return;
			end
			want = pending.pop_front();
			bad = (want.hx !== got.hx) || (want.hy !== got.hy) || (want.hz !== got.hz) ||
				(want.lx !== got.lx) || (want.ly !== got.ly) || (want.lz !== got.lz) ||
				(want.side !== got.side) || (want.last !== got.last) ||
				(want.covered !== got.covered);
			if (bad) begin
				if (mismatches < 10) begin
					$display("ERROR %0t: expected %s", $realtime, fmt(want));
					$display("                 got %s", fmt(got));
				end
				mismatches++;
			end
		endfunction
	endclass

	logic   clk;
	logic   arst_n;
	logic   push;
	logic   full;
	coord_t src_high_x, src_high_y, src_high_z, src_low_x, src_low_y, src_low_z;
	coord_t cut_high_x, cut_high_y, cut_high_z, cut_low_x, cut_low_y, cut_low_z;
	logic   empty;
	logic   pop;
	coord_t piece_high_x, piece_high_y, piece_high_z;
	coord_t piece_low_x, piece_low_y, piece_low_z;
	logic [2:0] piece_side;
	logic   piece_last;
	logic   no_pieces;

	piece_checker board = new();
	int send_idle;
	int recv_stall;
	bit hold_req;
	int hold_left;
	int quiet;

	box_subtract_split_top #(.COORD_BITS(COORD_BITS)) dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.src_high_x(src_high_x), .src_high_y(src_high_y), .src_high_z(src_high_z),
		.src_low_x(src_low_x), .src_low_y(src_low_y), .src_low_z(src_low_z),
		.cut_high_x(cut_high_x), .cut_high_y(cut_high_y), .cut_high_z(cut_high_z),
		.cut_low_x(cut_low_x), .cut_low_y(cut_low_y), .cut_low_z(cut_low_z),
		.empty(empty), .pop(pop),
		.piece_high_x(piece_high_x), .piece_high_y(piece_high_y),
		.piece_high_z(piece_high_z), .piece_low_x(piece_low_x),
		.piece_low_y(piece_low_y), .piece_low_z(piece_low_z),
		.piece_side(piece_side), .piece_last(piece_last), .no_pieces(no_pieces)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic boxes_t pack_boxes(input int sh[3], input int sl[3],
		input int ch[3], input int cl[3]);
		boxes_t b;
		b.shx = coord_t'(sh[AX_X]); b.shy = coord_t'(sh[AX_Y]); b.shz = coord_t'(sh[AX_Z]);
		b.slx = coord_t'(sl[AX_X]); b.sly = coord_t'(sl[AX_Y]); b.slz = coord_t'(sl[AX_Z]);
		b.chx = coord_t'(ch[AX_X]); b.chy = coord_t'(ch[AX_Y]); b.chz = coord_t'(ch[AX_Z]);
		b.clx = coord_t'(cl[AX_X]); b.cly = coord_t'(cl[AX_Y]); b.clz = coord_t'(cl[AX_Z]);
		return b;
	endfunction

	function automatic int extreme_coord();
		case ($urandom_range(6))
			0: return -32768;
			1: return -32767;
			2: return -1;
			3: return 0;
			4: return 1;
			5: return 32766;
			default: return 32767;
		endcase
	endfunction

	// mostly overlapping small boxes, some covered, some extremes, some noise
	function automatic boxes_t rand_boxes();
		int sh[3], sl[3], ch[3], cl[3];
		int kind, c, t;
		kind = $urandom_range(99);
		for (int a = 0; a < 3; a++) begin
			c = int'($urandom_range(65400)) - 32700;
			sl[a] = c - int'($urandom_range(20));
			sh[a] = c + int'($urandom_range(20));
			if (kind < 15) begin
				sh[a] = $urandom; sl[a] = $urandom; ch[a] = $urandom; cl[a] = $urandom;
			end else if (kind < 30) begin
				sh[a] = extreme_coord(); sl[a] = extreme_coord();
				ch[a] = extreme_coord(); cl[a] = extreme_coord();
			end else if (kind < 40) begin
				ch[a] = sh[a] + int'($urandom_range(3));
				cl[a] = sl[a] - int'($urandom_range(3));
			end else begin
				ch[a] = ($urandom_range(2) == 0) ? sh[a] + int'($urandom_range(3))
					: sl[a] + int'($urandom_range(sh[a] - sl[a]));
				cl[a] = ($urandom_range(2) == 0) ? sl[a] - int'($urandom_range(3))
					: sl[a] + int'($urandom_range(sh[a] - sl[a]));
				if (cl[a] > ch[a]) begin
					t = cl[a]; cl[a] = ch[a]; ch[a] = t;
				end
			end
		end
		return pack_boxes(sh, sl, ch, cl);
	endfunction

	task automatic send_boxes(boxes_t b);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(negedge clk);
		end
		{src_high_x, src_high_y, src_high_z, src_low_x, src_low_y, src_low_z,
			cut_high_x, cut_high_y, cut_high_z, cut_low_x, cut_low_y, cut_low_z} <= b;
		push <= 1'b1;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		pop = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_stall);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				board.note_boxes({src_high_x, src_high_y, src_high_z,
					src_low_x, src_low_y, src_low_z, cut_high_x, cut_high_y,
					cut_high_z, cut_low_x, cut_low_y, cut_low_z});
			if (pop && !empty)
				board.check_piece(piece_t'({piece_high_x, piece_high_y, piece_high_z,
					piece_low_x, piece_low_y, piece_low_z, piece_side, piece_last,
					no_pieces}));
			if ((push && !full) || (pop && !empty))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG) begin
				$display("box_subtract_split_top: mismatch");
				$finish;
			end
		end
	end

	initial begin
		int sh[3], sl[3], ch[3], cl[3];
		int ax;
		int idle_pct[4];
		int stall_pct[4];
		idle_pct  = '{0, 66, 0, 33};
		stall_pct = '{0, 0, 66, 33};
		send_idle = 0;
		recv_stall = 0;
		hold_req = 1'b0;
		quiet = 0;
		arst_n = 1'b0;
		push = 1'b0;
		{src_high_x, src_high_y, src_high_z, src_low_x, src_low_y, src_low_z,
			cut_high_x, cut_high_y, cut_high_z, cut_low_x, cut_low_y, cut_low_z} = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_boxes(pack_boxes('{9, 9, 9}, '{0, 0, 0}, '{9, 9, 9}, '{0, 0, 0}));
		send_boxes(pack_boxes('{9, 9, 9}, '{0, 0, 0}, '{20, 20, 20}, '{-5, -5, -5}));
		send_boxes(pack_boxes('{9, 9, 9}, '{0, 0, 0}, '{6, 6, 6}, '{3, 3, 3}));
		send_boxes(pack_boxes('{32767, 32767, 32767}, '{-32768, -32768, -32768},
			'{0, 0, 0}, '{0, 0, 0}));
		send_boxes(pack_boxes('{32767, 32767, 32767}, '{-32768, -32768, -32768},
			'{-32768, -32768, -32768}, '{-32768, -32768, -32768}));
		send_boxes(pack_boxes('{32767, 32767, 32767}, '{-32768, -32768, -32768},
			'{32767, 32767, 32767}, '{32767, 32767, 32767}));
		// disjoint and inverted boxes
		send_boxes(pack_boxes('{9, 9, 9}, '{0, 0, 0}, '{9, 9, 30}, '{0, 0, 20}));
		send_boxes(pack_boxes('{0, 0, 0}, '{9, 9, 9}, '{5, 5, 5}, '{4, 4, 4}));
		send_boxes(pack_boxes('{-32768, -32768, -32768}, '{-32768, -32768, -32768},
			'{-32768, -32768, -32768}, '{-32768, -32768, -32768}));
		send_boxes(pack_boxes('{32767, 32767, 32767}, '{32767, 32767, 32767},
			'{32767, 32767, 32767}, '{32767, 32767, 32767}));
		send_boxes(pack_boxes('{21845, 21845, 21845}, '{-21846, -21846, -21846},
			'{-21846, -21846, -21846}, '{21845, 21845, 21845}));
		// one side sticking out at a time
		for (int s = 0; s < 6; s++) begin
			sh = '{9, 9, 9}; sl = '{0, 0, 0}; ch = '{9, 9, 9}; cl = '{0, 0, 0};
			ax = 2 - s / 2;
			if (s % 2 == 0)
				ch[ax] = 5;
			else
				cl[ax] = 4;
			send_boxes(pack_boxes(sh, sl, ch, cl));
		end

		for (int ph = 0; ph < 4; ph++) begin
			send_idle = idle_pct[ph];
			recv_stall = stall_pct[ph];
			if (ph == 0)
				hold_req = 1'b1;
			repeat (73)
				send_boxes(rand_boxes());
		end
		@(negedge clk);
		push <= 1'b0;
		recv_stall = 0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("box_subtract_split_top: match");
		else
			$display("box_subtract_split_top: mismatch");
		$finish;
	end

endmodule

### files.f
hw/rtl/bss_pkg.sv
hw/rtl/bss_front.sv
hw/rtl/bss_queue.sv
hw/rtl/bss_back.sv
hw/rtl/box_subtract_split_top.sv
hw/rtl/bss_checker.sv
verif/box_subtract_split_top_tb.sv
